[src/aes_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, round constants and the byte-level round functions shared by the
// round stages.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS = 10;

    typedef logic [127:0] block_t;
    typedef logic [7:0]   byte_t;

    // Forward S-box.
    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Round constants for rounds one to ten.
    localparam logic [7:0] RCON [0:9] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam logic [7:0] GF_POLY = 8'h1B;

    // Byte n of a block sits at bits 127-8n down to 120-8n.
    function automatic byte_t get_byte(input block_t b, input int n);
        return b[127 - 8 * n -: 8];
    endfunction

    function automatic byte_t gf_double(input byte_t v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows.
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (c * 4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

    // MixColumns on all four columns.
    function automatic block_t mix(input block_t s);
        block_t t;
        byte_t  a [4];
        byte_t  all;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r] = get_byte(s, c * 4 + r);
            end
            all = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
            begin
                t[127 - 8 * (c * 4 + r) -: 8] = a[r] ^ all ^ gf_double(a[r] ^ a[(r + 1) % 4]);
            end
        end
        return t;
    endfunction

    // Next round key from the previous one.
    function automatic block_t next_key(input block_t p, input byte_t rc);
        block_t q;
        q[127:120] = get_byte(p, 0) ^ SBOX[get_byte(p, 13)] ^ rc;
        q[119:112] = get_byte(p, 1) ^ SBOX[get_byte(p, 14)];
        q[111:104] = get_byte(p, 2) ^ SBOX[get_byte(p, 15)];
        q[103:96]  = get_byte(p, 3) ^ SBOX[get_byte(p, 12)];
        for (int n = 4; n < 16; n++)
        begin
            q[127 - 8 * n -: 8] = get_byte(p, n) ^ q[127 - 8 * (n - 4) -: 8];
        end
        return q;
    endfunction

endpackage
`default_nettype wire

[src/aes_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES channel interfaces
// Valid/ready channels for the plaintext-and-key input and the ciphertext.
// ----------------------------------------------------------------------------
interface aes_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;

    modport source (output valid, plain_hi, plain_lo, key_hi, key_lo, input ready);
    modport sink   (input valid, plain_hi, plain_lo, key_hi, key_lo, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;

    modport source (output valid, cipher_hi, cipher_lo, input ready);
    modport sink   (input valid, cipher_hi, cipher_lo, output ready);
endinterface
`default_nettype wire

[src/aes128_block_encrypt_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encryption unit
// Eleven-stage pipeline of FIPS-197 AES-128 encryption with on-the-fly key
// expansion: a whitening stage and one stage for each of the ten rounds.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_ch    sink       plain_hi, plain_lo, key_hi, key_lo
//  out_ch   source     cipher_hi, cipher_lo
//
//  One transaction is accepted every cycle while the pipeline is not
//  halted. The depth is set by the ten round stages plus the whitening
//  stage. The whole pipeline moves as one: it halts only when the last
//  stage holds a result that is not taken, and accepts input while the
//  last stage is empty or being drained. Reset clears only the valid
//  bits.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit
    import aes_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    aes_in_if.sink    in_ch,
    aes_out_if.source out_ch
);

    logic   advance;
    logic   valid_w [NUM_ROUNDS + 1];
    block_t state_w [NUM_ROUNDS + 1];
    block_t key_w   [NUM_ROUNDS + 1];
    logic   valid0_reg;
    block_t state0_reg;
    block_t key0_reg;

    // The pipeline steps when the output stage is free or being drained.
    assign advance     = !valid_w[NUM_ROUNDS] || out_ch.ready;
    assign in_ch.ready = advance;

    // Whitening stage: add round key zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state0_reg <= {in_ch.plain_hi, in_ch.plain_lo} ^ {in_ch.key_hi, in_ch.key_lo};
            key0_reg   <= {in_ch.key_hi, in_ch.key_lo};
        end
    end

    assign valid_w[0] = valid0_reg;
    assign state_w[0] = state0_reg;
    assign key_w[0]   = key0_reg;

    // Ten round stages.
    for (genvar r = 1; r <= NUM_ROUNDS; r++)
    begin : g_round
        aes_round_stage #(
            .ROUND (r)
        ) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_w[r - 1]),
            .in_state  (state_w[r - 1]),
            .in_key    (key_w[r - 1]),
            .out_valid (valid_w[r]),
            .out_state (state_w[r]),
            .out_key   (key_w[r])
        );
    end

    assign out_ch.valid     = valid_w[NUM_ROUNDS];
    assign out_ch.cipher_hi = state_w[NUM_ROUNDS][127:64];
    assign out_ch.cipher_lo = state_w[NUM_ROUNDS][63:0];

endmodule
`default_nettype wire

[src/aes_round_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES round stage
// One pipeline stage: a full cipher round and the matching key expansion
// step, with a valid bit that travels alongside the data.
// ----------------------------------------------------------------------------
module aes_round_stage
    import aes_pkg::*;
#(
    parameter int ROUND = 1
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   in_valid,
    input  wire block_t in_state,
    input  wire block_t in_key,
    output logic        out_valid,
    output block_t      out_state,
    output block_t      out_key
);

    logic   valid_reg;
    block_t state_reg;
    block_t key_reg;
    block_t key_next;
    block_t state_next;

    // Round key and round transform; the last round skips MixColumns.
    always_comb
    begin
        key_next = next_key(in_key, RCON[ROUND - 1]);
        if (ROUND == NUM_ROUNDS)
        begin
            state_next = sub_shift(in_state) ^ key_next;
        end
        else
        begin
            state_next = mix(sub_shift(in_state)) ^ key_next;
        end
    end

    // Valid bit, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule
`default_nettype wire

[tb/aes128_block_encrypt_unit_tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The block's own channel interfaces are reused; this file holds the
// request and ciphertext record types used by the testbench.
// ----------------------------------------------------------------------------
package aes_tb_pkg;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } aes_req_t;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
    } aes_ct_t;

endpackage

[tb/tb_aes128_block_encrypt_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 encryption unit testbench
// Drives plaintext and key transactions with bursty timing, computes the
// expected ciphertext with an independent AES-128 model, and checks every
// ciphertext in order while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt_unit;
    import aes_pkg::*;
    import aes_tb_pkg::*;

    localparam int LATENCY     = 11;
    localparam int NUM_RANDOM  = 400;
    localparam int CYCLE_LIMIT = 200000;

    // Ciphertext predictor and in-order checker.
    class cipher_scoreboard;
        aes_ct_t pending_ct [$];
        int      mismatches;
        int      checked;

        function logic [7:0] sbox_lookup(input logic [7:0] v);
            logic [7:0] tbl [0:255];
            tbl = '{
                8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,
                8'hFE,8'hD7,8'hAB,8'h76,8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
                8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,8'hB7,8'hFD,8'h93,8'h26,
                8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
                8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,
                8'hEB,8'h27,8'hB2,8'h75,8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
                8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,8'h53,8'hD1,8'h00,8'hED,
                8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
                8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,
                8'h50,8'h3C,8'h9F,8'hA8,8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
                8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,8'hCD,8'h0C,8'h13,8'hEC,
                8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
                8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,
                8'hDE,8'h5E,8'h0B,8'hDB,8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
                8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,8'hE7,8'hC8,8'h37,8'h6D,
                8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
                8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,
                8'h4B,8'hBD,8'h8B,8'h8A,8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
                8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,8'hE1,8'hF8,8'h98,8'h11,
                8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
                8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,
                8'hB0,8'h54,8'hBB,8'h16
            };
            return tbl[v];
        endfunction

        function logic [7:0] xtime(input logic [7:0] v);
            return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
        endfunction

        // Full AES-128 encryption on byte arrays in column order.
        function aes_ct_t encrypt(input aes_req_t req);
            logic [7:0] st [16];
            logic [7:0] tmp [16];
            logic [7:0] rk [16];
            logic [7:0] rcon;
            logic [7:0] col [4];
            logic [7:0] sum;
            aes_ct_t    ct;
            for (int n = 0; n < 8; n++)
            begin
                st[n]     = req.plain_hi[63 - 8 * n -: 8];
                st[n + 8] = req.plain_lo[63 - 8 * n -: 8];
                rk[n]     = req.key_hi[63 - 8 * n -: 8];
                rk[n + 8] = req.key_lo[63 - 8 * n -: 8];
            end
            for (int n = 0; n < 16; n++)
                st[n] ^= rk[n];
            rcon = 8'h01;
            for (int rnd = 1; rnd <= 10; rnd++)
            begin
                // Round key for this round.
                tmp[0] = rk[0] ^ sbox_lookup(rk[13]) ^ rcon;
                tmp[1] = rk[1] ^ sbox_lookup(rk[14]);
                tmp[2] = rk[2] ^ sbox_lookup(rk[15]);
                tmp[3] = rk[3] ^ sbox_lookup(rk[12]);
                for (int n = 4; n < 16; n++)
                    tmp[n] = rk[n] ^ tmp[n - 4];
                rk = tmp;
                rcon = xtime(rcon);
                // Substitution and row rotation.
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        tmp[c * 4 + r] = sbox_lookup(st[((c + r) % 4) * 4 + r]);
                st = tmp;
                // Column mixing, skipped in the last round.
                if (rnd != 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int r = 0; r < 4; r++)
                            col[r] = st[c * 4 + r];
                        sum = col[0] ^ col[1] ^ col[2] ^ col[3];
                        for (int r = 0; r < 4; r++)
                            st[c * 4 + r] = col[r] ^ sum ^ xtime(col[r] ^ col[(r + 1) % 4]);
                    end
                end
                for (int n = 0; n < 16; n++)
                    st[n] ^= rk[n];
            end
            for (int n = 0; n < 8; n++)
            begin
                ct.cipher_hi[63 - 8 * n -: 8] = st[n];
                ct.cipher_lo[63 - 8 * n -: 8] = st[n + 8];
            end
            return ct;
        endfunction

        function void note_input(input aes_req_t req);
            pending_ct.push_back(encrypt(req));
        endfunction

        task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
            mismatches++;
            $display("MISMATCH %s: got %016h expected %016h", what, got, want);
        endtask

        task automatic check_cipher(input aes_ct_t got);
            aes_ct_t want;
            checked++;
            if (pending_ct.size() == 0)
            begin
                report("unexpected ciphertext", got.cipher_hi, 64'h0);
            end
            else
            begin
                want = pending_ct.pop_front();
                if (got.cipher_hi !== want.cipher_hi)
                    report("cipher_hi", got.cipher_hi, want.cipher_hi);
                if (got.cipher_lo !== want.cipher_lo)
                    report("cipher_lo", got.cipher_lo, want.cipher_lo);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   long_hold;
    bit   stim_done;

    aes_in_if  in_ch ();
    aes_out_if out_ch ();

    cipher_scoreboard ciphers;
    aes_req_t         directed_reqs [$];

    aes128_block_encrypt_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Clock generator.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Cycle counter with a watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Sample both channels at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            ciphers.note_input({in_ch.plain_hi, in_ch.plain_lo, in_ch.key_hi, in_ch.key_lo});
        if (rst_n && out_ch.valid && out_ch.ready)
            ciphers.check_cipher({out_ch.cipher_hi, out_ch.cipher_lo});
    end

    // Receiver: a stall pattern of its own, plus a long hold-off each time the stimulus asks for one.
    initial
    begin
        int hold_cycles;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles = 60;
                repeat (hold_cycles) @(negedge clk);
                long_hold = 1'b0;
            end
            if (stim_done && cycle_count[9])
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 3) != 0) || (cycle_count[8:6] == 3'd5);
        end
    end

    // Offer one transaction and hold it until accepted.
    task automatic send_block(input aes_req_t req);
        in_ch.valid    <= 1'b1;
        in_ch.plain_hi <= req.plain_hi;
        in_ch.plain_lo <= req.plain_lo;
        in_ch.key_hi   <= req.key_hi;
        in_ch.key_lo   <= req.key_lo;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random field with a bias towards the extremes and single-bit patterns.
    function automatic logic [63:0] rand_field();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 64'h0;
        else if (sel == 1)
            return '1;
        else if (sel == 2)
            return 64'h1 << $urandom_range(0, 63);
        else
            return rand64();
    endfunction

    // Stimulus.
    initial
    begin
        aes_req_t req;
        int       burst;
        int       sent;
        ciphers        = new();
        cycle_count    = 0;
        long_hold      = 1'b0;
        stim_done      = 1'b0;
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.plain_hi = '0;
        in_ch.plain_lo = '0;
        in_ch.key_hi   = '0;
        in_ch.key_lo   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: the standard example vectors, all-zero and all-one fields, single-bit and alternating patterns.
        directed_reqs.push_back({64'h00112233_44556677, 64'h8899aabb_ccddeeff,
                                 64'h00010203_04050607, 64'h08090a0b_0c0d0e0f});
        directed_reqs.push_back({64'h3243f6a8_885a308d, 64'h313198a2_e0370734,
                                 64'h2b7e1516_28aed2a6, 64'habf71588_09cf4f3c});
        directed_reqs.push_back({64'h0, 64'h0, 64'h0, 64'h0});
        directed_reqs.push_back({64'hffffffff_ffffffff, 64'hffffffff_ffffffff,
                                 64'hffffffff_ffffffff, 64'hffffffff_ffffffff});
        directed_reqs.push_back({64'h0, 64'h0, 64'hffffffff_ffffffff, 64'hffffffff_ffffffff});
        directed_reqs.push_back({64'hffffffff_ffffffff, 64'hffffffff_ffffffff, 64'h0, 64'h0});
        directed_reqs.push_back({64'h80000000_00000000, 64'h0, 64'h0, 64'h1});
        directed_reqs.push_back({64'h0, 64'h1, 64'h80000000_00000000, 64'h0});
        directed_reqs.push_back({64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555,
                                 64'h55555555_55555555, 64'haaaaaaaa_aaaaaaaa});
        foreach (directed_reqs[i])
            send_block(directed_reqs[i]);
        idle_gap(3);

        // Random part: bursts with gaps, and long receiver hold-offs early on.
        sent = 0;
        while (sent < NUM_RANDOM)
        begin
            burst = $urandom_range(1, 24);
            if (sent > 40 && sent < 70)
                long_hold = 1'b1;
            for (int b = 0; b < burst && sent < NUM_RANDOM; b++)
            begin
                req.plain_hi = rand_field();
                req.plain_lo = rand_field();
                req.key_hi   = rand_field();
                req.key_lo   = rand_field();
                send_block(req);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 15));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        // Drain and let the pipeline settle.
        while (ciphers.pending_ct.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 3) @(posedge clk);

        $display("Checked %0d ciphertexts from %0d directed and %0d random blocks.",
                 ciphers.checked, directed_reqs.size(), NUM_RANDOM);
        $display("Stimulus covered extreme keys and plaintexts, bursts and a long stall.");
        if (ciphers.mismatches == 0 && ciphers.pending_ct.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
src/aes_pkg.sv
src/aes_if.sv
src/aes_round_stage.sv
src/aes128_block_encrypt_unit.sv
tb/aes128_block_encrypt_unit_tb_if.sv
tb/tb_aes128_block_encrypt_unit.sv
